/* hdl/sphere_frustum_cull_top_macros.svh */
// Assertion macros for the sphere frustum cull block.
// No dependencies; included by the modules that carry assertions.
`ifndef SPHERE_FRUSTUM_CULL_TOP_MACROS_SVH
`define SPHERE_FRUSTUM_CULL_TOP_MACROS_SVH
`ifndef SYNTHESIS
// clocked check, disabled while reset is low
`define SFC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also holds during reset
`define SFC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SFC_ASSERT(lbl, clk, rst_n, prop, msg)
`define SFC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* hdl/sfc_pkg.sv */
// Shared types and constants for the sphere frustum cull block.
// No dependencies.
package sfc_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int NUM_PLANES    = 6;
    localparam int MAT_W         = 32;          // matrix element, Q16.16
    localparam int C_W           = 32;          // centre coordinate
    localparam int R_W           = 31;          // radius
    localparam int R2_W          = 2 * R_W;     // radius squared
    localparam int N_W           = MAT_W + 1;   // plane component
    localparam int P_W           = N_W + C_W;   // n * c product
    localparam int Q_W           = 2 * MAT_W + 1; // n * n, never above 2^64
    localparam int L_W           = Q_W + 2;     // sum of three squares

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;

    typedef enum logic [1:0] {
        VIS_OUTSIDE = 2'd0,
        VIS_TOUCH   = 2'd1,
        VIS_INSIDE  = 2'd2
    } t_vis;

    // stage advance strobes handed to each plane unit
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic s6;
        logic s7;
    } t_plane_en;
endpackage

/* hdl/sphere_frustum_cull_top.sv */
// Sphere frustum cull: a load transfer writes one element of the stored 4x4
// column-major matrix and takes effect for the next test; a test transfer
// classifies a sphere against the six planes derived from that matrix and
// gives one result (outside, intersecting, inside) at the end of the pipeline. One
// item is taken per cycle while o_stall is low; it passes through the eight-stage
// pipeline, two of whose stages are the split wide multipliers. Loads give no result.
module sphere_frustum_cull_top #(
    parameter int FRAC_BITS = sfc_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_op,
    input  logic [1:0]                     i_mat_col,
    input  logic [1:0]                     i_mat_row,
    input  logic signed [sfc_pkg::MAT_W-1:0] i_element_value,
    input  logic signed [sfc_pkg::C_W-1:0] i_centre_x,
    input  logic signed [sfc_pkg::C_W-1:0] i_centre_y,
    input  logic signed [sfc_pkg::C_W-1:0] i_centre_z,
    input  logic [sfc_pkg::R_W-1:0]        i_radius,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [1:0]                     o_visibility
);
    import sfc_pkg::*;
    `include "sphere_frustum_cull_top_macros.svh"

    localparam int NST = 8;

    logic signed [MAT_W-1:0] r_mat [4][4];       // [col][row]
    logic [NST:1]            r_vld;
    logic [NST:1]            en;
    logic                    acc;
    logic                    acc_test;
    logic signed [N_W-1:0]   n_pl [NUM_PLANES][4];
    logic signed [N_W-1:0]   r_pl [NUM_PLANES][4];
    logic signed [C_W-1:0]   r_c1 [3];
    logic [R_W-1:0]          r_r1;
    logic [R2_W-1:0]         r_r2_s2;
    logic [R2_W-1:0]         r_r2_s3;
    logic [R2_W-1:0]         r_r2_s4;
    t_plane_en               pen;
    t_vis                    cls [NUM_PLANES];
    t_vis                    n_vis;
    logic [1:0]              r_vis;

    // stage advance: a stage moves when empty or when the next one moves
    always_comb begin
        en[NST] = !r_vld[NST] || !i_stall;
        for (int s = NST - 1; s >= 1; s--) begin
            en[s] = !r_vld[s] || en[s+1];
        end
    end

    assign o_stall  = !en[1];
    assign acc      = i_valid && en[1];
    assign acc_test = acc && (i_op == OP_TEST);

    // matrix store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < 4; c++) begin
                for (int r = 0; r < 4; r++) r_mat[c][r] <= '0;
            end
        end else if (acc && (i_op == OP_LOAD)) begin
            r_mat[i_mat_col][i_mat_row] <= i_element_value;
        end
    end

    // plane components: row 3 minus/plus row axis; slot 3 is w
    always_comb begin
        for (int p = 0; p < NUM_PLANES; p++) begin
            for (int k = 0; k < 4; k++) begin
                if ((p & 1) == 1)
                    n_pl[p][k] = N_W'(r_mat[k][3]) + N_W'(r_mat[k][p >> 1]);
                else
                    n_pl[p][k] = N_W'(r_mat[k][3]) - N_W'(r_mat[k][p >> 1]);
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) r_vld[1] <= acc_test;
            for (int s = 2; s <= NST; s++) begin
                if (en[s]) r_vld[s] <= r_vld[s-1];
            end
        end
    end

    // stage 1 capture
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_pl    <= n_pl;
            r_c1[0] <= i_centre_x;
            r_c1[1] <= i_centre_y;
            r_c1[2] <= i_centre_z;
            r_r1    <= i_radius;
        end
    end

    // radius squared, delayed to meet the plane multipliers
    always_ff @(posedge i_clk) begin
        if (en[2]) r_r2_s2 <= R2_W'(r_r1) * R2_W'(r_r1);
        if (en[3]) r_r2_s3 <= r_r2_s2;
        if (en[4]) r_r2_s4 <= r_r2_s3;
    end

    assign pen = '{s2: en[2], s3: en[3], s4: en[4], s5: en[5], s6: en[6], s7: en[7]};

    for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
        sfc_plane #(.FRAC_BITS(FRAC_BITS)) u_plane (
            .i_clk   (i_clk),
            .i_en    (pen),
            .i_n     ('{r_pl[p][0], r_pl[p][1], r_pl[p][2]}),
            .i_w     (r_pl[p][3]),
            .i_c     (r_c1),
            .i_r2    (r_r2_s4),
            .o_class (cls[p])
        );
    end

    // worst class over all planes
    always_comb begin
        n_vis = VIS_INSIDE;
        for (int p = 0; p < NUM_PLANES; p++) begin
            if (cls[p] < n_vis) n_vis = cls[p];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[NST]) r_vis <= n_vis;
    end

    assign o_valid      = r_vld[NST];
    assign o_visibility = r_vis;

    `SFC_ASSERT(a_test_enters, i_clk, i_rst_n, acc_test |=> r_vld[1], "test transfer lost at entry")
    `SFC_ASSERT(a_stage7_hold, i_clk, i_rst_n, (r_vld[7] && !en[8]) |=> r_vld[7], "held stage dropped")
    `SFC_ASSERT(a_stall_full, i_clk, i_rst_n, o_stall |-> (r_vld[1] && r_vld[NST]), "stall with room")
endmodule

/* hdl/sfc_wmul.sv */
// Two-stage unsigned multiplier built from four half-width partial products.
// Depends on nothing but its parameters.
module sfc_wmul #(
    parameter int AW = 67,
    parameter int BW = 67
) (
    input  logic             i_clk,
    input  logic             i_en_pp,
    input  logic             i_en_sum,
    input  logic [AW-1:0]    i_a,
    input  logic [BW-1:0]    i_b,
    output logic [AW+BW-1:0] o_p
);
    localparam int AL = AW / 2;
    localparam int AH = AW - AL;
    localparam int BL = BW / 2;
    localparam int BH = BW - BL;
    localparam int PW = AW + BW;

    logic [AL+BL-1:0] r_ll;
    logic [AL+BH-1:0] r_lh;
    logic [AH+BL-1:0] r_hl;
    logic [AH+BH-1:0] r_hh;
    logic [PW-1:0]    r_p;

    // partial products
    always_ff @(posedge i_clk) begin
        if (i_en_pp) begin
            r_ll <= (AL+BL)'(i_a[AL-1:0]) * (AL+BL)'(i_b[BL-1:0]);
            r_lh <= (AL+BH)'(i_a[AL-1:0]) * (AL+BH)'(i_b[BW-1:BL]);
            r_hl <= (AH+BL)'(i_a[AW-1:AL]) * (AH+BL)'(i_b[BL-1:0]);
            r_hh <= (AH+BH)'(i_a[AW-1:AL]) * (AH+BH)'(i_b[BW-1:BL]);
        end
    end

    // weighted sum
    always_ff @(posedge i_clk) begin
        if (i_en_sum) begin
            r_p <= PW'(r_ll) + (PW'(r_lh) << BL) + (PW'(r_hl) << AL)
                 + (PW'(r_hh) << (AL + BL));
        end
    end

    assign o_p = r_p;
endmodule

/* hdl/sfc_plane.sv */
// One frustum plane: signed distance, squared compare of d*d against r*r*L, class.
// Depends on sfc_pkg and sfc_wmul.
module sfc_plane #(
    parameter int FRAC_BITS = sfc_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  sfc_pkg::t_plane_en             i_en,
    input  logic signed [sfc_pkg::N_W-1:0] i_n [3],
    input  logic signed [sfc_pkg::N_W-1:0] i_w,
    input  logic signed [sfc_pkg::C_W-1:0] i_c [3],
    input  logic [sfc_pkg::R2_W-1:0]       i_r2,
    output sfc_pkg::t_vis                  o_class
);
    import sfc_pkg::*;

    // width of the exact distance in Q(2F)
    localparam int WS_W = N_W + FRAC_BITS;
    localparam int SW   = ((WS_W > P_W) ? WS_W : P_W) + 2;
    localparam int CW   = 2 * SW;
    localparam int RLW  = L_W + R2_W;

    logic signed [P_W-1:0] r_p [3];
    logic [Q_W-1:0]        r_q [3];
    logic signed [N_W-1:0] r_w2;
    logic signed [SW-1:0]  r_d3;
    logic [L_W-1:0]        r_l3;
    logic [L_W-1:0]        r_l4;
    logic [SW-1:0]         r_ad4;
    logic                  r_neg4;
    logic                  r_neg5;
    logic                  r_neg6;
    logic [CW-1:0]         d2;
    logic [RLW-1:0]        rl2;
    logic [CW-1:0]         rl2_x;
    t_vis                  r_class;
    t_vis                  n_class;

    // products n*c and squares n*n
    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            for (int k = 0; k < 3; k++) begin
                r_p[k] <= P_W'(i_n[k]) * P_W'(i_c[k]);
                r_q[k] <= $unsigned(Q_W'(i_n[k] * i_n[k]));
            end
            r_w2 <= i_w;
        end
    end

    // distance and squared length of xyz
    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_d3 <= SW'(r_p[0]) + SW'(r_p[1]) + SW'(r_p[2]) + (SW'(r_w2) <<< FRAC_BITS);
            r_l3 <= L_W'(r_q[0]) + L_W'(r_q[1]) + L_W'(r_q[2]);
        end
    end

    // magnitude and sign of the distance
    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_neg4 <= r_d3[SW-1];
            r_ad4  <= r_d3[SW-1] ? $unsigned(-r_d3) : $unsigned(r_d3);
            r_l4   <= r_l3;
        end
    end

    sfc_wmul #(.AW(SW), .BW(SW)) u_dsq (
        .i_clk    (i_clk),
        .i_en_pp  (i_en.s5),
        .i_en_sum (i_en.s6),
        .i_a      (r_ad4),
        .i_b      (r_ad4),
        .o_p      (d2)
    );

    sfc_wmul #(.AW(L_W), .BW(R2_W)) u_rl (
        .i_clk    (i_clk),
        .i_en_pp  (i_en.s5),
        .i_en_sum (i_en.s6),
        .i_a      (r_l4),
        .i_b      (i_r2),
        .o_p      (rl2)
    );

    // sign travels with the multiplier stages
    always_ff @(posedge i_clk) begin
        if (i_en.s5) r_neg5 <= r_neg4;
        if (i_en.s6) r_neg6 <= r_neg5;
    end

    // classify against this plane
    assign rl2_x = CW'(rl2);
    always_comb begin
        if (r_neg6 && (d2 > rl2_x)) n_class = VIS_OUTSIDE;
        else if (r_neg6 || (d2 < rl2_x)) n_class = VIS_TOUCH;
        else n_class = VIS_INSIDE;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s7) r_class <= n_class;
    end

    assign o_class = r_class;
endmodule

/* test/sphere_frustum_cull_top_tb.sv */
// Self-checking testbench for the sphere frustum cull block: matrix loads and
// sphere tests with random idling and stalls, results checked against a model.
// Depends on sfc_pkg and sphere_frustum_cull_top.
module sphere_frustum_cull_top_tb;
    import sfc_pkg::*;

    localparam int FB    = FRAC_BITS_DEF;
    localparam int LIMIT = 400000;

    typedef struct {
        logic                    op;
        logic [1:0]              col;
        logic [1:0]              row;
        logic signed [31:0]      elem;
        logic signed [31:0]      cx;
        logic signed [31:0]      cy;
        logic signed [31:0]      cz;
        logic [30:0]             rad;
    } t_item;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic i_op = OP_LOAD;
    logic [1:0] i_mat_col = '0;
    logic [1:0] i_mat_row = '0;
    logic signed [31:0] i_element_value = '0;
    logic signed [31:0] i_centre_x = '0;
    logic signed [31:0] i_centre_y = '0;
    logic signed [31:0] i_centre_z = '0;
    logic [30:0] i_radius = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [1:0] o_visibility;

    t_item pending_items[$];
    t_vis  expected_vis[$];
    logic signed [31:0] frustum_mat[16];
    int   fails = 0;
    int   cycle_count = 0;
    int   send_idle_pct = 0;
    int   stall_pct = 0;
    int   hold_cycles = 0;
    logic started = 1'b0;

    sphere_frustum_cull_top DUT (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // classify one plane: 0 outside, 1 touching, 2 in front
    function automatic int plane_class(int axis, bit plus, t_item it);
        logic signed [127:0] d, n, w, l2, r;
        logic signed [31:0]  c[3];
        logic [255:0]        d2, rl2;
        c[0] = it.cx; c[1] = it.cy; c[2] = it.cz;
        d = 0; l2 = 0;
        for (int k = 0; k < 3; k++) begin
            n = plus ? 128'(frustum_mat[k*4+3]) + 128'(frustum_mat[k*4+axis])
                     : 128'(frustum_mat[k*4+3]) - 128'(frustum_mat[k*4+axis]);
            l2 += n * n;
            d += n * 128'(c[k]);
        end
        w = plus ? 128'(frustum_mat[15]) + 128'(frustum_mat[12+axis])
                 : 128'(frustum_mat[15]) - 128'(frustum_mat[12+axis]);
        d += w <<< FB;
        r = {97'b0, it.rad};
        d2 = 256'(d < 0 ? -d : d);
        d2 = d2 * d2;
        rl2 = 256'(r * r) * 256'(l2);
        if (d < 0 && d2 > rl2) return 0;
        if (d < 0 || d2 < rl2) return 1;
        return 2;
    endfunction

    function automatic t_vis sphere_visibility(t_item it);
        int res = 2;
        for (int a = 0; a < 3; a++)
            for (int p = 0; p < 2; p++) begin
                int t = plane_class(a, p[0], it);
                if (t < res) res = t;
            end
        return t_vis'(res);
    endfunction

    // predictor runs at acceptance, in transfer order
    function automatic void apply_item(t_item it);
        if (it.op == OP_LOAD)
            frustum_mat[{it.col, it.row}] = it.elem;
        else
            expected_vis.push_back(sphere_visibility(it));
    endfunction

    function automatic t_item load_item(int col, int row, logic signed [31:0] v);
        t_item it;
        it = '{default: '0};
        it.op = OP_LOAD; it.col = 2'(col); it.row = 2'(row); it.elem = v;
        return it;
    endfunction

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'sh8000_0000;
            2: return 32'sh7fff_ffff;
            default: return $signed($urandom_range(0, 32'h000a_0000)) - 32'sh0005_0000;
        endcase
    endfunction

    function automatic t_item test_item();
        t_item it;
        it = '{default: '0};
        it.op = OP_TEST;
        it.cx = rand_coord(); it.cy = rand_coord(); it.cz = rand_coord();
        case ($urandom_range(0, 4))
            0: it.rad = 31'($urandom());
            1: it.rad = 0;
            default: it.rad = 31'($urandom_range(0, 32'h0003_0000));
        endcase
        // unused load fields still toggle
        it.col = 2'($urandom()); it.row = 2'($urandom()); it.elem = $urandom();
        return it;
    endfunction

    function automatic logic signed [31:0] rand_elem();
        case ($urandom_range(0, 6))
            0: return $urandom();
            1: return 32'sh8000_0000;
            2: return 32'sh7fff_ffff;
            3: return 0;
            default: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
        endcase
    endfunction

    // driver: next item offered when the previous one was taken
    always @(posedge i_clk) begin
        if (i_rst_n && started) begin
            if (!i_valid || !o_stall) begin
                if (i_valid) apply_item(pending_items.pop_front());
                if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_valid         <= 1'b1;
                    i_op            <= pending_items[0].op;
                    i_mat_col       <= pending_items[0].col;
                    i_mat_row       <= pending_items[0].row;
                    i_element_value <= pending_items[0].elem;
                    i_centre_x      <= pending_items[0].cx;
                    i_centre_y      <= pending_items[0].cy;
                    i_centre_z      <= pending_items[0].cz;
                    i_radius        <= pending_items[0].rad;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall, with a long hold-off when requested
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // monitor: compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_vis.size() == 0) begin
                $error("result with none expected: visibility %0d", o_visibility);
                fails++;
            end else begin
                t_vis e;
                e = expected_vis.pop_front();
                if (o_visibility !== e) begin
                    $error("visibility: expected %0d actual %0d", e, o_visibility);
                    fails++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic drain();
        wait (pending_items.size() == 0 && !i_valid);
        wait (expected_vis.size() == 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic run_phase(int idle, int stl, int n);
        send_idle_pct = idle;
        stall_pct = stl;
        for (int i = 0; i < n; i++) begin
            // mostly tests, with matrix loads and occasional full reloads
            if ($urandom_range(0, 99) < 3)
                for (int e = 0; e < 16; e++)
                    pending_items.push_back(load_item(e / 4, e % 4, rand_elem()));
            else if ($urandom_range(0, 99) < 15)
                pending_items.push_back(load_item($urandom_range(0, 3),
                                                  $urandom_range(0, 3), rand_elem()));
            else
                pending_items.push_back(test_item());
        end
        drain();
    endtask

    initial begin
        t_item it;
        foreach (frustum_mat[i]) frustum_mat[i] = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        started <= 1'b1;

        // reset matrix: every sphere inside
        it = test_item(); it.rad = 31'h7fff_ffff;
        pending_items.push_back(it);
        // identity-like matrix in Q16.16
        for (int e = 0; e < 4; e++)
            pending_items.push_back(load_item(e, e, 32'sh0001_0000));
        it = '{default: '0}; it.op = OP_TEST;
        pending_items.push_back(it);                       // centre, zero radius
        it.cx = 32'sh0001_0000; pending_items.push_back(it); // on boundary plane
        it.cx = 32'sh0002_0000; pending_items.push_back(it); // point outside
        it.rad = 31'h0001_0000; pending_items.push_back(it); // tangent from outside
        it.rad = 31'h0002_0000; pending_items.push_back(it); // intersecting
        it.cx = 32'sh8000_0000; it.cy = 32'sh7fff_ffff; it.cz = 32'sh8000_0000;
        it.rad = 31'h7fff_ffff; pending_items.push_back(it);
        it.cx = 0; it.cy = 0; it.cz = 0; it.rad = 31'h0000_8000;
        pending_items.push_back(it);                       // inside
        // extreme elements, degenerate planes
        pending_items.push_back(load_item(0, 0, 32'sh8000_0000));
        pending_items.push_back(load_item(3, 3, 32'sh7fff_ffff));
        pending_items.push_back(load_item(0, 3, 32'sh8000_0000));
        pending_items.push_back(test_item());
        pending_items.push_back(test_item());
        drain();

        run_phase(0, 0, 210);
        run_phase(55, 0, 210);
        run_phase(0, 55, 210);
        run_phase(38, 38, 210);

        // long hold-off while the sender keeps offering
        send_idle_pct = 0;
        stall_pct = 0;
        hold_cycles = 300;
        for (int i = 0; i < 200; i++) pending_items.push_back(test_item());
        drain();

        if (fails == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

/* sphere_frustum_cull_top.f */
+incdir+hdl
hdl/sfc_pkg.sv
hdl/sfc_wmul.sv
hdl/sfc_plane.sv
hdl/sphere_frustum_cull_top.sv
test/sphere_frustum_cull_top_tb.sv
